// ----- design/lhd_pkg.sv -----
// ----------------------------------------------------------------------------
// lhd_pkg: shared types and constants for the layered header decoder
// Input/result transfer structs, status codes and the payload count cap.
// ----------------------------------------------------------------------------
package lhd_pkg;

	// Longest message the payload counter is sized for
	localparam int unsigned MAX_MSG_BYTES = 256;
	localparam int unsigned PAY_W         = 9;
	localparam int unsigned PAY_MAX       = (1 << PAY_W) - 1;
	localparam int unsigned PAY_CAP_INT   = (MAX_MSG_BYTES < PAY_MAX) ? MAX_MSG_BYTES : PAY_MAX;
	localparam logic [PAY_W-1:0] PAY_CAP  = PAY_W'(PAY_CAP_INT);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ROUTED    = 3'd1,
		ST_BAD_NET   = 3'd2,
		ST_BAD_TRANS = 3'd3,
		ST_SHORT     = 3'd4
	} lhd_status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} lhd_in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [1:0]       net_id;
		logic [15:0]      dest_addr;
		logic [15:0]      src_addr;
		logic [7:0]       net_flags;
		logic             trans_id;
		logic [7:0]       seq_num;
		logic [7:0]       win_size;
		logic [7:0]       trans_flags;
		logic [15:0]      service_id;
		logic [7:0]       service_status;
		logic [PAY_W-1:0] payload_length;
	} lhd_out_t;

endpackage

// ----- design/layered_header_decoder.sv -----
// ----------------------------------------------------------------------------
// layered_header_decoder: byte-serial network/transport/service header parser
// Captures header fields per byte, counts payload, emits one result per message.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one message byte per transfer (in_valid / in_stall), with
//           last_byte set on the final byte of a message.
//   out_* : one decoded result per message (out_valid / out_stall), holding
//           header fields, payload byte count and a status code.
//   cfg_* : own_device_addr, written with cfg_we; write only while idle.
// Throughput: one byte per cycle while in_stall is low. The per-byte field capture is
//   a single pass through the phase/byte counter logic into the state regs.
// Result: the last byte's result is registered into out_q or the skid entry.
// Stall: results sit in an output register backed by a one-entry skid
//   register. Input keeps flowing while one result waits; in_stall rises
//   (registered) only once the skid entry is also occupied.
// Reset: arst_n clears the parse state to the network-id phase, empties the
//   output and skid registers and sets own_device_addr to zero.
// After each last byte the parse state returns to the network-id phase.
// ----------------------------------------------------------------------------
module layered_header_decoder
	import lhd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// byte input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  lhd_in_t    in_data,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output lhd_out_t   out_data,
	// configuration
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	typedef enum logic [2:0] {
		PH_NET_ID     = 3'd0,
		PH_NET_BODY   = 3'd1,
		PH_TRANS_ID   = 3'd2,
		PH_TRANS_BODY = 3'd3,
		PH_SERVICE    = 3'd4,
		PH_PAYLOAD    = 3'd5,
		PH_DONE       = 3'd6
	} phase_t;

	// Body length of each network header type
	function automatic logic [2:0] net_body_len(input logic [1:0] id);
		logic [2:0] len;
		unique case (id)
			2'd0: len = 3'd0;
			2'd1: len = 3'd2;
			2'd2: len = 3'd4;
			2'd3: len = 3'd5;
		endcase
		return len;
	endfunction

	// Parse state
	phase_t           phase_q, phase_d;
	logic [2:0]       idx_q, idx_d;
	lhd_status_t      status_q, status_d;
	logic [1:0]       net_id_q, net_id_d;
	logic [15:0]      dest_q, dest_d;
	logic [15:0]      src_q, src_d;
	logic [7:0]       nflags_q, nflags_d;
	logic             tid_q, tid_d;
	logic [7:0]       seq_q, seq_d;
	logic [7:0]       win_q, win_d;
	logic [7:0]       tflags_q, tflags_d;
	logic [15:0]      svc_id_q, svc_id_d;
	logic [7:0]       svc_st_q, svc_st_d;
	logic [PAY_W-1:0] pay_q, pay_d;

	logic [7:0] own_addr_q;

	// Output register and skid entry
	lhd_out_t out_q, skid_q, res;
	logic     out_vld_q, skid_vld_q;

	logic       in_xfer, res_valid, net_done, out_pop, main_free;
	logic [7:0] b;
	logic [2:0] idx_inc;
	lhd_status_t res_status;

	assign in_xfer   = in_valid & ~in_stall;
	assign res_valid = in_xfer & in_data.last_byte;
	assign b         = in_data.data_byte;
	assign idx_inc   = idx_q + 3'd1;

	// Next parse state for the incoming byte
	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		status_d = status_q;
		net_id_d = net_id_q;
		dest_d   = dest_q;
		src_d    = src_q;
		nflags_d = nflags_q;
		tid_d    = tid_q;
		seq_d    = seq_q;
		win_d    = win_q;
		tflags_d = tflags_q;
		svc_id_d = svc_id_q;
		svc_st_d = svc_st_q;
		pay_d    = pay_q;
		net_done = 1'b0;

		unique case (phase_q)
			PH_NET_ID: begin
				if (b > 8'd3) begin
					status_d = ST_BAD_NET;
					phase_d  = PH_DONE;
				end else begin
					net_id_d = b[1:0];
					idx_d    = 3'd0;
					if (net_body_len(b[1:0]) == 3'd0) begin
						net_done = 1'b1;
					end else begin
						phase_d = PH_NET_BODY;
					end
				end
			end
			PH_NET_BODY: begin
				if (net_id_q == 2'd1) begin
					if (idx_q == 3'd0) begin
						dest_d = {8'h00, b};
					end else begin
						src_d = {8'h00, b};
					end
				end else begin
					unique case (idx_q)
						3'd0:    dest_d[15:8] = b;
						3'd1:    dest_d[7:0]  = b;
						3'd2:    src_d[15:8]  = b;
						3'd3:    src_d[7:0]   = b;
						default: nflags_d     = b;
					endcase
				end
				idx_d = idx_inc;
				if (idx_inc >= net_body_len(net_id_q)) begin
					net_done = 1'b1;
				end
			end
			PH_TRANS_ID: begin
				if (b > 8'd1) begin
					status_d = ST_BAD_TRANS;
					phase_d  = PH_DONE;
				end else begin
					tid_d   = b[0];
					idx_d   = 3'd0;
					phase_d = b[0] ? PH_TRANS_BODY : PH_SERVICE;
				end
			end
			PH_TRANS_BODY: begin
				unique case (idx_q)
					3'd0:    seq_d    = b;
					3'd1:    win_d    = b;
					default: tflags_d = b;
				endcase
				idx_d = idx_inc;
				if (idx_inc >= 3'd3) begin
					idx_d   = 3'd0;
					phase_d = PH_SERVICE;
				end
			end
			PH_SERVICE: begin
				unique case (idx_q)
					3'd0: begin
						svc_id_d[15:8] = b;
						idx_d          = 3'd1;
					end
					3'd1: begin
						svc_id_d[7:0] = b;
						// status byte follows on odd service ids
						if (b[0]) begin
							idx_d = 3'd2;
						end else begin
							idx_d   = 3'd0;
							phase_d = PH_PAYLOAD;
						end
					end
					default: begin
						svc_st_d = b;
						idx_d    = 3'd0;
						phase_d  = PH_PAYLOAD;
					end
				endcase
			end
			PH_PAYLOAD: begin
				if (pay_q < PAY_CAP) begin
					pay_d = pay_q + PAY_W'(1);
				end
			end
			default: ;
		endcase

		// Network header complete: route foreign devices under net id 2, else go to transport
		if (net_done) begin
			idx_d = 3'd0;
			if (net_id_d == 2'd2 && dest_d[15:8] != own_addr_q) begin
				status_d = ST_ROUTED;
				phase_d  = PH_PAYLOAD;
			end else begin
				phase_d = PH_TRANS_ID;
			end
		end
	end

	// Result assembled from the post-byte state
	always_comb begin
		res_status = status_d;
		if (phase_d != PH_PAYLOAD && phase_d != PH_DONE) begin
			res_status = ST_SHORT;
		end
		res.status         = res_status;
		res.net_id         = net_id_d;
		res.dest_addr      = dest_d;
		res.src_addr       = src_d;
		res.net_flags      = nflags_d;
		res.trans_id       = tid_d;
		res.seq_num        = seq_d;
		res.win_size       = win_d;
		res.trans_flags    = tflags_d;
		res.service_id     = svc_id_d;
		res.service_status = svc_st_d;
		res.payload_length = (res_status == ST_OK || res_status == ST_ROUTED) ?
			pay_d : '0;
	end

	// Parse state registers; the last byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NET_ID;
			idx_q    <= '0;
			status_q <= ST_OK;
			net_id_q <= '0;
			dest_q   <= '0;
			src_q    <= '0;
			nflags_q <= '0;
			tid_q    <= 1'b0;
			seq_q    <= '0;
			win_q    <= '0;
			tflags_q <= '0;
			svc_id_q <= '0;
			svc_st_q <= '0;
			pay_q    <= '0;
		end else if (in_xfer) begin
			if (in_data.last_byte) begin
				phase_q  <= PH_NET_ID;
				idx_q    <= '0;
				status_q <= ST_OK;
				net_id_q <= '0;
				dest_q   <= '0;
				src_q    <= '0;
				nflags_q <= '0;
				tid_q    <= 1'b0;
				seq_q    <= '0;
				win_q    <= '0;
				tflags_q <= '0;
				svc_id_q <= '0;
				svc_st_q <= '0;
				pay_q    <= '0;
			end else begin
				phase_q  <= phase_d;
				idx_q    <= idx_d;
				status_q <= status_d;
				net_id_q <= net_id_d;
				dest_q   <= dest_d;
				src_q    <= src_d;
				nflags_q <= nflags_d;
				tid_q    <= tid_d;
				seq_q    <= seq_d;
				win_q    <= win_d;
				tflags_q <= tflags_d;
				svc_id_q <= svc_id_d;
				svc_st_q <= svc_st_d;
				pay_q    <= pay_d;
			end
		end
	end

	// Own device address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
		end else if (cfg_we) begin
			own_addr_q <= cfg_wdata;
		end
	end

	// Output register with one skid entry behind it
	assign out_pop   = out_vld_q & ~out_stall;
	assign main_free = ~out_vld_q | out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (main_free) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign in_stall  = skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ----- design/lhd_checker.sv -----
// ----------------------------------------------------------------------------
// lhd_checker: port-level checks for the layered header decoder
// Watches the result channel for hold behavior and status/field consistency.
// ----------------------------------------------------------------------------
module lhd_checker
	import lhd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input lhd_out_t   out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_SHORT)
		else $error("status code out of range");

	a_err_no_pay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_BAD_NET || out_data.status == ST_BAD_TRANS ||
			out_data.status == ST_SHORT) |-> out_data.payload_length == '0)
		else $error("payload count on error result");

	a_bad_net_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_BAD_NET |->
			out_data.net_id == '0 && out_data.dest_addr == '0 &&
			out_data.service_id == '0 && out_data.trans_id == 1'b0)
		else $error("fields set after bad network id");

	a_pay_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.payload_length <= PAY_CAP)
		else $error("payload count above cap");

endmodule

bind layered_header_decoder lhd_checker u_lhd_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for layered_header_decoder
// Sends whole messages one byte per transfer. A local decoder model predicts
// each message's result, and every result transfer is compared field by field.
// The sender idles and the receiver stalls at random, and the own device address is
// rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lhd_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 5;
	localparam int ITEM_TARGET    = 1150;
	// settle time after the last expected result has been taken
	localparam int DRAIN_CYCLES   = 4;
	// well above the longest sender gap plus the longest receiver stall
	localparam int WATCHDOG_LIMIT = 2000;

	// protocol ids as they appear on the wire
	localparam int         NET_ID_MAX      = 3;
	localparam int         TRANS_ID_MAX    = 1;
	localparam logic [1:0] NET_ID_NONE     = 2'd0;
	localparam logic [1:0] NET_ID_SHORT    = 2'd1;	// one-byte addresses
	localparam logic [1:0] NET_ID_DEV_CHAN = 2'd2;	// device/channel addresses
	localparam logic [1:0] NET_ID_FULL     = 2'd3;	// 16-bit addresses plus flags
	localparam logic       TRANS_WITH_BODY = 1'b1;

	// where the decoder is within a message
	typedef enum logic [2:0] {
		AT_NET_ID,
		AT_NET_BODY,
		AT_TRANS_ID,
		AT_TRANS_BODY,
		AT_SERVICE,
		AT_PAYLOAD,
		AT_SKIP
	} parse_phase_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	lhd_in_t    in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	lhd_out_t   out_data;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = '0;

	layered_header_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Decoder model state: mirrors the block's parse registers and the
	// own device address as last written.
	// ------------------------------------------------------------------
	parse_phase_t phase;
	logic [2:0]   pos;			// byte index within the current layer
	lhd_status_t  parse_status;
	lhd_out_t     fields;		// captured fields; payload_length is the running count
	logic [7:0]   own_addr;

	lhd_out_t   expected_results[$];
	logic [7:0] msg_bytes[$];		// message being built for transfer

	int  errors          = 0;
	int  bytes_sent      = 0;
	int  messages_sent   = 0;
	int  results_checked = 0;
	int  addr_writes     = 0;
	int  status_hits[5]  = '{default: 0};
	int  quiet_cycles    = 0;
	int  stall_left      = 0;
	bit  idle_on         = 1'b1;	// cleared for stretches of back-to-back traffic

	function automatic int net_body_len(input logic [1:0] nid);
		case (nid)
			NET_ID_NONE:     return 0;
			NET_ID_SHORT:    return 2;
			NET_ID_DEV_CHAN: return 4;
			default:         return 5;
		endcase
	endfunction

	function automatic void clear_parse();
		phase        = AT_NET_ID;
		pos          = '0;
		parse_status = ST_OK;
		fields       = '0;
	endfunction

	// Advance the model by one accepted byte; queue a result on the last one.
	task automatic predict_byte(input logic [7:0] b, input logic lst);
		bit       net_complete;
		lhd_out_t res;
		net_complete = 1'b0;
		case (phase)
			AT_NET_ID: begin
				if (b > NET_ID_MAX) begin
					parse_status = ST_BAD_NET;
					phase        = AT_SKIP;
				end else begin
					fields.net_id = b[1:0];
					pos           = '0;
					if (net_body_len(b[1:0]) == 0)
						net_complete = 1'b1;
					else
						phase = AT_NET_BODY;
				end
			end
			AT_NET_BODY: begin
				if (fields.net_id == NET_ID_SHORT) begin
					// single-byte addresses land in the low byte
					if (pos == 0)
						fields.dest_addr = {8'h00, b};
					else
						fields.src_addr = {8'h00, b};
				end else begin
					case (pos)
						3'd0:    fields.dest_addr[15:8] = b;
						3'd1:    fields.dest_addr[7:0]  = b;
						3'd2:    fields.src_addr[15:8]  = b;
						3'd3:    fields.src_addr[7:0]   = b;
						default: fields.net_flags       = b;
					endcase
				end
				pos++;
				if (pos >= net_body_len(fields.net_id))
					net_complete = 1'b1;
			end
			AT_TRANS_ID: begin
				if (b > TRANS_ID_MAX) begin
					parse_status = ST_BAD_TRANS;
					phase        = AT_SKIP;
				end else begin
					fields.trans_id = b[0];
					pos             = '0;
					phase           = (b[0] == TRANS_WITH_BODY) ? AT_TRANS_BODY : AT_SERVICE;
				end
			end
			AT_TRANS_BODY: begin
				case (pos)
					3'd0:    fields.seq_num     = b;
					3'd1:    fields.win_size    = b;
					default: fields.trans_flags = b;
				endcase
				pos++;
				if (pos == 3) begin
					pos   = '0;
					phase = AT_SERVICE;
				end
			end
			AT_SERVICE: begin
				if (pos == 0) begin
					fields.service_id[15:8] = b;
					pos = 3'd1;
				end else if (pos == 1) begin
					fields.service_id[7:0] = b;
					// odd service ids carry a status byte
					if (b[0]) begin
						pos = 3'd2;
					end else begin
						pos   = '0;
						phase = AT_PAYLOAD;
					end
				end else begin
					fields.service_status = b;
					pos   = '0;
					phase = AT_PAYLOAD;
				end
			end
			AT_PAYLOAD: begin
				if (fields.payload_length < PAY_CAP)
					fields.payload_length++;
			end
			default: ;
		endcase

		// foreign device under device/channel addressing: skip the upper layers
		if (net_complete) begin
			if (fields.net_id == NET_ID_DEV_CHAN && fields.dest_addr[15:8] != own_addr) begin
				parse_status = ST_ROUTED;
				phase        = AT_PAYLOAD;
			end else begin
				phase = AT_TRANS_ID;
			end
			pos = '0;
		end

		if (lst) begin
			res = fields;
			res.status = (phase == AT_PAYLOAD || phase == AT_SKIP) ? parse_status : ST_SHORT;
			if (res.status != ST_OK && res.status != ST_ROUTED)
				res.payload_length = '0;
			expected_results.push_back(res);
			clear_parse();
		end
	endtask

	// Mostly short gaps, now and then a long one; none while idle_on is low.
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// ------------------------------------------------------------------
	// Byte channel: one transfer per call. Valid stays high into the next
	// call when there is no gap, so it is never dropped and raised in one step.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{data_byte: b, last_byte: lst};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_byte(b, lst);
		bytes_sent++;
	endtask

	task automatic send_message();
		foreach (msg_bytes[i])
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		messages_sent++;
	endtask

	// Stop sending and wait for every queued result, then for the pipeline
	// to settle, so the block is idle for a register write.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_own_addr(input logic [7:0] a);
		cfg_we    <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we   <= 1'b0;
		own_addr = a;
		addr_writes++;
	endtask

	// Append well-formed network, transport and service headers with random
	// content. For device/channel addressing to_self picks our own device.
	function automatic void push_headers(input logic [1:0] nid, input bit to_self,
		input logic tid);
		logic [15:0] svc;
		int          body;
		body = net_body_len(nid);
		msg_bytes.push_back({6'd0, nid});
		for (int i = 0; i < body; i++) begin
			if (i == 0 && nid == NET_ID_DEV_CHAN)
				msg_bytes.push_back(to_self ? own_addr : own_addr ^ 8'($urandom_range(1, 255)));
			else
				msg_bytes.push_back(8'($urandom));
		end
		msg_bytes.push_back({7'd0, tid});
		if (tid == TRANS_WITH_BODY)
			repeat (3) msg_bytes.push_back(8'($urandom));
		svc = 16'($urandom);
		msg_bytes.push_back(svc[15:8]);
		msg_bytes.push_back(svc[7:0]);
		if (svc[0])
			msg_bytes.push_back(8'($urandom));
	endfunction

	// Mostly well-formed messages; the rest cut short, with a bad id, or noise.
	task automatic send_random_message();
		logic [1:0] nid;
		int         kind;
		int         pay;
		int         cut;
		nid  = 2'($urandom_range(0, 3));
		kind = $urandom_range(0, 99);
		msg_bytes.delete();
		push_headers(nid, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		pay = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
		repeat (pay) msg_bytes.push_back(8'($urandom));
		if (kind >= 94) begin
			msg_bytes.delete();
			repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
		end else if (kind >= 87) begin
			msg_bytes[1 + net_body_len(nid)] = 8'($urandom_range(TRANS_ID_MAX + 1, 255));
		end else if (kind >= 80) begin
			msg_bytes[0] = 8'($urandom_range(NET_ID_MAX + 1, 255));
		end else if (kind >= 68) begin
			// any cut point, down to a lone first byte
			cut = $urandom_range(1, msg_bytes.size());
			while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
		end
		send_message();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		// lone bad network id
		msg_bytes = '{8'hFF};
		send_message();
		// ends right after network id 0, before the transport id byte
		msg_bytes = '{8'h00};
		send_message();
		// device AB is foreign to the reset address 0: routed, one payload byte
		msg_bytes = '{8'h02, 8'hAB, 8'h01, 8'h02, 8'h03, 8'h99};
		send_message();
		// full addressing, transport body, odd service id with its status byte
		msg_bytes = '{8'h03, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hA5, 8'h01, 8'hFF, 8'h00,
			8'h80, 8'hFF, 8'hFF, 8'h77};
		send_message();
		// bad transport id
		msg_bytes = '{8'h00, 8'h02};
		send_message();
	endtask

	task automatic test_own_address();
		logic [7:0] settings[4];
		settings = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom)};
		foreach (settings[s]) begin
			wait_drained();
			write_own_addr(settings[s]);
			repeat (5) begin
				msg_bytes.delete();
				push_headers(NET_ID_DEV_CHAN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
				send_message();
			end
		end
	endtask

	task automatic test_payload_saturation();
		msg_bytes.delete();
		push_headers(NET_ID_NONE, 1'b1, 1'b0);
		repeat (PAY_CAP_INT + $urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
		send_message();
	endtask

	task automatic test_random_traffic();
		int         batch;
		logic [7:0] addr;
		batch = 0;
		while (bytes_sent < ITEM_TARGET) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if (batch % 5 == 4) begin
				case ($urandom_range(0, 3))
					0:       addr = 8'h00;
					1:       addr = 8'hFF;
					default: addr = 8'($urandom);
				endcase
				wait_drained();
				write_own_addr(addr);
			end
			repeat (8) send_random_message();
			batch++;
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Result channel: random back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (idle_on && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		lhd_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, out_data);
			end else begin
				want = expected_results.pop_front();
				check_field("status", 16'(want.status), 16'(out_data.status));
				check_field("net_id", 16'(want.net_id), 16'(out_data.net_id));
				check_field("dest_addr", want.dest_addr, out_data.dest_addr);
				check_field("src_addr", want.src_addr, out_data.src_addr);
				check_field("net_flags", 16'(want.net_flags), 16'(out_data.net_flags));
				check_field("trans_id", 16'(want.trans_id), 16'(out_data.trans_id));
				check_field("seq_num", 16'(want.seq_num), 16'(out_data.seq_num));
				check_field("win_size", 16'(want.win_size), 16'(out_data.win_size));
				check_field("trans_flags", 16'(want.trans_flags),
					16'(out_data.trans_flags));
				check_field("service_id", want.service_id, out_data.service_id);
				check_field("service_status", 16'(want.service_status),
					16'(out_data.service_status));
				check_field("payload_length", 16'(want.payload_length),
					16'(out_data.payload_length));
				status_hits[want.status]++;
				results_checked++;
			end
		end
	end

	// Ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		clear_parse();
		own_addr = 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_own_address();
		test_payload_saturation();
		test_random_traffic();
		wait_drained();

		$display("Covered %0d bytes in %0d messages, %0d own-address writes, %0d results checked",
			bytes_sent, messages_sent, addr_writes, results_checked);
		$display("By status: ok %0d, routed %0d, bad network %0d, bad transport %0d, short %0d",
			status_hits[ST_OK], status_hits[ST_ROUTED], status_hits[ST_BAD_NET],
			status_hits[ST_BAD_TRANS], status_hits[ST_SHORT]);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lhd_pkg.sv
design/layered_header_decoder.sv
design/lhd_checker.sv
tb/sv/tb.sv
